@@ src/line_sensor_array_calibrate_locate_defines.svh @@
// assertion macros for the line sensor block
`ifndef LINE_SENSOR_ARRAY_CALIBRATE_LOCATE_DEFINES_SVH
`define LINE_SENSOR_ARRAY_CALIBRATE_LOCATE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LSA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define LSA_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LSA_ASSERT(label, clk, rstn, prop)
`define LSA_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ src/lsa_pkg.sv @@
// ----------------------------------------------------------------------------
// lsa_pkg
// shared constants and types of the line sensor array block
// ----------------------------------------------------------------------------
package lsa_pkg;
    localparam int SENSOR_COUNT = 6;
    localparam int SIDX_W = $clog2(SENSOR_COUNT);
    localparam logic [15:0] TIMEOUT_TICKS = 16'hFFFF;
    localparam logic [9:0] LEVEL_FULL = 10'd1000;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_CAL = 2'd1;
    localparam logic [1:0] KIND_MEASURE = 2'd2;

    localparam logic [2:0] LINE_NONE = 3'd0;
    localparam logic [2:0] LINE_STRAIGHT = 3'd1;
    localparam logic [2:0] LINE_LEFT = 3'd2;
    localparam logic [2:0] LINE_RIGHT = 3'd3;
    localparam logic [2:0] LINE_FULL = 3'd4;

    localparam logic [1:0] REG_WHITE = 2'd0;
    localparam logic [1:0] REG_NOISE = 2'd1;
    localparam logic [1:0] REG_LINE = 2'd2;
    localparam logic [1:0] REG_SIDE = 2'd3;

    // divider operands: 27-bit dividend magnitude, 17-bit divisor magnitude
    localparam int DIV_NW = 27;
    localparam int DIV_DW = 17;

    typedef struct packed {
        logic                start;
        logic [DIV_NW-1:0]   num;
        logic [DIV_DW-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic                busy;
        logic [DIV_NW-1:0]   quo;
    } div_rsp_t;
endpackage

@@ src/lsa_divider.sv @@
// ----------------------------------------------------------------------------
// lsa_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsa_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsa_pkg::div_req_t req,
    output lsa_pkg::div_rsp_t rsp
);
    import lsa_pkg::*;
    `include "line_sensor_array_calibrate_locate_defines.svh"

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   trial;

    // one shift-subtract step per cycle
    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[DIV_NW-1]} - {1'b0, den_reg};
        if (req.start) begin
            quo_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = CNT_W'(DIV_NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_DW]) begin
                rem_next = trial[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DIV_DW-2:0], quo_reg[DIV_NW-1]};
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        if (!aresetn) begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.quo = quo_reg;

    `LSA_ASSERT(a_done_after_busy, aclk, aresetn, rsp.done |-> !busy_reg)
    `LSA_ASSERT(a_busy_counts, aclk, aresetn, busy_reg |-> cnt_reg != '0)
    `LSA_ASSERT(a_done_one_cycle, aclk, aresetn, done_reg |=> !done_reg)
endmodule

@@ src/line_sensor_array_calibrate_locate.sv @@
// ----------------------------------------------------------------------------
// line_sensor_array_calibrate_locate
// calibration and weighted line location for a six-sensor reflectance array
// ----------------------------------------------------------------------------
// one scan beat enters on s_axis; kind 0 clears the calibration, kind 1 widens
// each sensor's min/max, kind 2 measures and gives one m_axis beat with six
// levels, the line position and the line kind; kind 3 is dropped.
// clear, calibrate and dropped beats are taken while idle and can follow back
// to back. a measure beat runs the six level divisions, the position sums and
// the position division (skipped on a zero sum) before its result beat is
// loaded, and the next scan is taken only after that; one shared bit-serial
// divider does all of these divisions.
// s_axis_tready is low while a measure is in progress.
// a stall on m_axis holds the result in the output register; further scans
// are still taken, and a following measure waits in its last state until
// the held beat leaves.
// reset (aresetn low, synchronous) sets the calibration to min 65535, max 0
// and the registers to 0, 64, 96, 1500. the user writes registers through
// cfg_we / cfg_addr / cfg_wdata only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module line_sensor_array_calibrate_locate (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: raw_0 .. raw_5, 16 bits each, low bits first
    input  logic [95:0]  s_axis_tdata,
    // tuser: kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: level_0 .. level_5 (10 each), line_position (13), line_kind (3)
    output logic [79:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [12:0]  cfg_wdata
);
    import lsa_pkg::*;
    `include "line_sensor_array_calibrate_locate_defines.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LSTART = 3'd1;
    localparam logic [2:0] ST_LWAIT = 3'd2;
    localparam logic [2:0] ST_PSUM = 3'd3;
    localparam logic [2:0] ST_PWAIT = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    logic [2:0] st_reg, st_next;
    logic [15:0] cmin_reg [SENSOR_COUNT];
    logic [15:0] cmax_reg [SENSOR_COUNT];
    logic [15:0] raw_reg [SENSOR_COUNT];
    logic [9:0]  lv_reg [SENSOR_COUNT];
    logic [SIDX_W-1:0] idx_reg;
    logic neg_reg, zero_reg;
    logic white_reg;
    logic [9:0] noise_reg, lthr_reg;
    logic [12:0] side_reg;
    logic [25:0] acc_reg;
    logic [12:0] sum_reg;
    logic [12:0] pos_reg;
    logic [2:0]  lkind_reg;
    logic        mvalid_reg;
    logic [79:0] mdata_reg;
    logic [79:0] res_word;
    logic        m_free;

    div_req_t dreq;
    div_rsp_t drsp;

    lsa_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // level operands for the sensor at idx
    logic signed [17:0] num_s, den_s;
    logic signed [27:0] prod_s;
    logic [DIV_NW-1:0] num_mag;
    logic [DIV_DW-1:0] den_mag;
    always_comb begin
        num_s = $signed({2'b0, raw_reg[idx_reg]}) - $signed({2'b0, cmin_reg[idx_reg]});
        den_s = $signed({2'b0, cmax_reg[idx_reg]}) - $signed({2'b0, cmin_reg[idx_reg]});
        prod_s = 28'(num_s) * 28'sd1000;
        num_mag = prod_s[27] ? DIV_NW'(-prod_s) : DIV_NW'(prod_s);
        den_mag = den_s[17] ? DIV_DW'(-den_s) : DIV_DW'(den_s);
    end

    // clamp of the signed quotient
    logic [9:0] lv_new;
    always_comb begin
        if (zero_reg || drsp.quo == '0) lv_new = '0;
        else if (neg_reg) lv_new = '0;
        else if (drsp.quo > DIV_NW'(LEVEL_FULL)) lv_new = LEVEL_FULL;
        else lv_new = drsp.quo[9:0];
    end

    // position terms, one sensor a cycle
    logic [9:0] pv;
    logic [12:0] wgt;
    always_comb begin
        pv = white_reg ? LEVEL_FULL - lv_reg[idx_reg] : lv_reg[idx_reg];
        wgt = 13'(({10'd0, idx_reg} + 13'd1) * 13'd1000);
    end

    // line classification from the finished levels
    logic [2:0] cls;
    logic [12:0] lsum, rsum, tsum;
    logic all_dark, ol, orr;
    always_comb begin
        lsum = '0;
        rsum = '0;
        all_dark = 1'b1;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (lv_reg[i] < lthr_reg) all_dark = 1'b0;
            if (lv_reg[i] > lthr_reg) begin
                if (i < SENSOR_COUNT / 2) lsum = lsum + 13'(lv_reg[i]);
                else rsum = rsum + 13'(lv_reg[i]);
            end
        end
        tsum = lsum + rsum;
        ol = lv_reg[0] >= lthr_reg;
        orr = lv_reg[SENSOR_COUNT-1] >= lthr_reg;
        if (all_dark) cls = LINE_FULL;
        else if (ol && !orr && lsum > side_reg && rsum < side_reg) cls = LINE_LEFT;
        else if (!ol && orr && rsum > side_reg && lsum < side_reg) cls = LINE_RIGHT;
        else if (ol && orr && rsum > side_reg && lsum > side_reg) cls = LINE_FULL;
        else if (tsum == '0) cls = LINE_NONE;
        else cls = LINE_STRAIGHT;
    end

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (st_reg == ST_IDLE);
    assign m_free = !mvalid_reg || m_axis_tready;

    // sequencer
    always_comb begin
        st_next = st_reg;
        dreq.start = 1'b0;
        dreq.num = num_mag;
        dreq.den = den_mag;
        case (st_reg)
            ST_IDLE: if (s_acc && s_axis_tuser == KIND_MEASURE) st_next = ST_LSTART;
            ST_LSTART: begin
                dreq.start = 1'b1;
                st_next = ST_LWAIT;
            end
            ST_LWAIT: if (drsp.done) begin
                st_next = (idx_reg == SIDX_W'(SENSOR_COUNT - 1)) ? ST_PSUM : ST_LSTART;
            end
            ST_PSUM: if (idx_reg == SIDX_W'(SENSOR_COUNT - 1)) st_next = ST_PWAIT;
            ST_PWAIT: begin
                if (!drsp.busy && !drsp.done && sum_reg != '0) begin
                    dreq.start = 1'b1;
                    dreq.num = DIV_NW'(acc_reg);
                    dreq.den = DIV_DW'(sum_reg);
                end
                if (drsp.done || sum_reg == '0) st_next = ST_OUT;
            end
            ST_OUT: if (m_free) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // result word from the finished measure
    always_comb begin
        for (int i = 0; i < SENSOR_COUNT; i++) res_word[10*i +: 10] = lv_reg[i];
        res_word[72:60] = pos_reg;
        res_word[75:73] = lkind_reg;
        res_word[79:76] = '0;
    end

    // datapath and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            mvalid_reg <= 1'b0;
            white_reg <= 1'b0;
            noise_reg <= 10'd64;
            lthr_reg <= 10'd96;
            side_reg <= 13'd1500;
            idx_reg <= '0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                cmin_reg[i] <= TIMEOUT_TICKS;
                cmax_reg[i] <= '0;
            end
        end else begin
            st_reg <= st_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_WHITE: white_reg <= cfg_wdata[0];
                    REG_NOISE: noise_reg <= cfg_wdata[9:0];
                    REG_LINE: lthr_reg <= cfg_wdata[9:0];
                    REG_SIDE: side_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // output beat valid flag
            if (st_reg == ST_OUT && m_free) mvalid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) mvalid_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: if (s_acc) begin
                    idx_reg <= '0;
                    acc_reg <= '0;
                    sum_reg <= '0;
                    for (int i = 0; i < SENSOR_COUNT; i++) begin
                        raw_reg[i] <= (s_axis_tdata[16*i +: 16] == TIMEOUT_TICKS)
                            ? cmax_reg[i] : s_axis_tdata[16*i +: 16];
                        if (s_axis_tuser == KIND_CLEAR) begin
                            cmin_reg[i] <= TIMEOUT_TICKS;
                            cmax_reg[i] <= '0;
                        end else if (s_axis_tuser == KIND_CAL) begin
                            if (s_axis_tdata[16*i +: 16] != TIMEOUT_TICKS) begin
                                if (s_axis_tdata[16*i +: 16] < cmin_reg[i])
                                    cmin_reg[i] <= s_axis_tdata[16*i +: 16];
                                if (s_axis_tdata[16*i +: 16] > cmax_reg[i])
                                    cmax_reg[i] <= s_axis_tdata[16*i +: 16];
                            end else if (cmax_reg[i] < cmin_reg[i]) begin
                                cmin_reg[i] <= cmax_reg[i];
                            end
                        end
                    end
                end
                ST_LSTART: begin
                    neg_reg <= prod_s[27] ^ den_s[17];
                    zero_reg <= den_s == '0;
                end
                ST_LWAIT: if (drsp.done) begin
                    lv_reg[idx_reg] <= lv_new;
                    idx_reg <= (idx_reg == SIDX_W'(SENSOR_COUNT - 1)) ? '0 : idx_reg + 1'b1;
                end
                ST_PSUM: begin
                    if (pv > noise_reg) begin
                        acc_reg <= acc_reg + 26'(pv) * 26'(wgt);
                        sum_reg <= sum_reg + 13'(pv);
                    end
                    idx_reg <= (idx_reg == SIDX_W'(SENSOR_COUNT - 1)) ? '0 : idx_reg + 1'b1;
                end
                ST_PWAIT: if (drsp.done || sum_reg == '0) begin
                    pos_reg <= (sum_reg == '0) ? '0 : drsp.quo[12:0];
                    lkind_reg <= cls;
                end
                ST_OUT: if (m_free) mdata_reg <= res_word;
                default: ;
            endcase
        end
    end

    assign m_axis_tdata = mdata_reg;
    assign m_axis_tvalid = mvalid_reg;

    `LSA_ASSERT(a_no_accept_busy, aclk, aresetn, (st_reg != ST_IDLE) |-> !s_axis_tready)
    `LSA_ASSERT(a_out_hold, aclk, aresetn,
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    `LSA_ASSERT(a_out_wait, aclk, aresetn,
        (st_reg == ST_OUT && m_axis_tvalid && !m_axis_tready) |=> st_reg == ST_OUT)
endmodule

@@ tb/line_sensor_array_calibrate_locate_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_sensor_array_calibrate_locate_tb
// self-checking bench for calibration and line location
// ----------------------------------------------------------------------------
// scan beats are queued by a stimulus process and sent by a bursty driver;
// each accepted measure beat is predicted from a local copy of calibration and
// registers, and every result beat is compared field by field in order.
// ----------------------------------------------------------------------------
module line_sensor_array_calibrate_locate_tb;
    import lsa_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [95:0] raw;
    } scan_t;

    typedef struct packed {
        logic [2:0]  lkind;
        logic [12:0] pos;
        logic [9:0]  lvl5, lvl4, lvl3, lvl2, lvl1, lvl0;
    } meas_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [12:0] cfg_wdata = '0;

    line_sensor_array_calibrate_locate DUT (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // predictor state
    logic [15:0] mdl_min [SENSOR_COUNT];
    logic [15:0] mdl_max [SENSOR_COUNT];
    logic        mdl_white;
    logic [9:0]  mdl_noise, mdl_line;
    logic [12:0] mdl_side;

    scan_t  scan_q [$];
    meas_t  meas_q [$];
    int     errors = 0;
    int     results_seen = 0;
    int     burst_left = 0, gap_left = 0;
    logic   hold_tx = 1'b0;

    function automatic logic [9:0] level_calc(int i, logic [15:0] r);
        int den, x;
        den = int'(mdl_max[i]) - int'(mdl_min[i]);
        x = 0;
        if (den != 0) x = ((int'(r) - int'(mdl_min[i])) * 1000) / den;
        if (x < 0) x = 0;
        else if (x > 1000) x = 1000;
        return x[9:0];
    endfunction

    // apply one scan to the predictor, queue a result for a measure beat
    task automatic predict_scan(scan_t sc);
        logic [15:0] r [SENSOR_COUNT];
        int lv [SENSOR_COUNT];
        longint acc;
        int sum, v, lsum, rsum, k;
        bit dark;
        meas_t m;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            r[i] = sc.raw[16*i +: 16];
            if (r[i] == TIMEOUT_TICKS) r[i] = mdl_max[i];
        end
        if (sc.kind == KIND_CLEAR) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                mdl_min[i] = 16'hFFFF;
                mdl_max[i] = 16'h0;
            end
        end else if (sc.kind == KIND_CAL) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (r[i] < mdl_min[i]) mdl_min[i] = r[i];
                if (r[i] > mdl_max[i]) mdl_max[i] = r[i];
            end
        end else if (sc.kind == KIND_MEASURE) begin
            acc = 0; sum = 0; lsum = 0; rsum = 0; dark = 1;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                lv[i] = level_calc(i, r[i]);
                v = mdl_white ? 1000 - lv[i] : lv[i];
                if (v > mdl_noise) begin
                    acc += longint'(v) * (1000 * (i + 1));
                    sum += v;
                end
                if (lv[i] < mdl_line) dark = 0;
            end
            m.lvl0 = lv[0]; m.lvl1 = lv[1]; m.lvl2 = lv[2];
            m.lvl3 = lv[3]; m.lvl4 = lv[4]; m.lvl5 = lv[5];
            m.pos = (sum == 0) ? 13'd0 : 13'(acc / sum);
            sum = 0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (lv[i] > mdl_line) begin
                    sum += lv[i];
                    if (i < SENSOR_COUNT / 2) lsum += lv[i];
                    else rsum += lv[i];
                end
            end
            if (dark) k = LINE_FULL;
            else if (lv[0] >= mdl_line && lv[5] < mdl_line && lsum > mdl_side
                     && rsum < mdl_side) k = LINE_LEFT;
            else if (lv[0] < mdl_line && lv[5] >= mdl_line && rsum > mdl_side
                     && lsum < mdl_side) k = LINE_RIGHT;
            else if (lv[0] >= mdl_line && lv[5] >= mdl_line && rsum > mdl_side
                     && lsum > mdl_side) k = LINE_FULL;
            else if (sum == 0) k = LINE_NONE;
            else k = LINE_STRAIGHT;
            m.lkind = k[2:0];
            meas_q.push_back(m);
        end
    endtask

    // driver: bursts with random gaps
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_scan({s_axis_tuser, s_axis_tdata});
                void'(scan_q.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the beat
            end else if (scan_q.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                         && !hold_tx && gap_left == 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= scan_q[0].raw;
                s_axis_tuser <= scan_q[0].kind;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 300);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // receiver stall pattern and result check
    always @(posedge aclk) begin
        meas_t got, exp_m;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[75:0];
                results_seen++;
                if (meas_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    exp_m = meas_q.pop_front();
                    if (got.lvl0 !== exp_m.lvl0) begin
                        $error("level_0 exp %0d got %0d", exp_m.lvl0, got.lvl0); errors++; end
                    if (got.lvl1 !== exp_m.lvl1) begin
                        $error("level_1 exp %0d got %0d", exp_m.lvl1, got.lvl1); errors++; end
                    if (got.lvl2 !== exp_m.lvl2) begin
                        $error("level_2 exp %0d got %0d", exp_m.lvl2, got.lvl2); errors++; end
                    if (got.lvl3 !== exp_m.lvl3) begin
                        $error("level_3 exp %0d got %0d", exp_m.lvl3, got.lvl3); errors++; end
                    if (got.lvl4 !== exp_m.lvl4) begin
                        $error("level_4 exp %0d got %0d", exp_m.lvl4, got.lvl4); errors++; end
                    if (got.lvl5 !== exp_m.lvl5) begin
                        $error("level_5 exp %0d got %0d", exp_m.lvl5, got.lvl5); errors++; end
                    if (got.pos !== exp_m.pos) begin
                        $error("line_position exp %0d got %0d", exp_m.pos, got.pos);
                        errors++;
                    end
                    if (got.lkind !== exp_m.lkind) begin
                        $error("line_kind exp %0d got %0d", exp_m.lkind, got.lkind);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 3) != 0) || (results_seen % 16 < 4);
        end
    end

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'hFFFE;
            3: return 16'($urandom);
            default: return 16'($urandom_range(100, 2500));
        endcase
    endfunction

    function automatic scan_t make_scan(logic [1:0] k);
        scan_t s;
        s.kind = k;
        for (int i = 0; i < SENSOR_COUNT; i++) s.raw[16*i +: 16] = rand_raw();
        return s;
    endfunction

    function automatic scan_t fill_scan(logic [1:0] k, logic [15:0] v);
        scan_t s;
        s.kind = k;
        s.raw = {SENSOR_COUNT{v}};
        return s;
    endfunction

    task automatic drain();
        while (scan_q.size() != 0 || s_axis_tvalid || meas_q.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WHITE: mdl_white = val[0];
            REG_NOISE: mdl_noise = val[9:0];
            REG_LINE:  mdl_line = val[9:0];
            default:   mdl_side = val;
        endcase
    endtask

    // a clear, a calibration run of one to five scans, then random scans: mostly measures, some cal, clear or kind 3
    task automatic queue_session(int meas_n);
        scan_q.push_back(make_scan(KIND_CLEAR));
        repeat ($urandom_range(1, 5)) scan_q.push_back(make_scan(KIND_CAL));
        repeat (meas_n) begin
            case ($urandom_range(0, 19))
                0: scan_q.push_back(make_scan(2'd3));
                1: scan_q.push_back(make_scan(KIND_CAL));
                2: scan_q.push_back(make_scan(KIND_CLEAR));
                default: scan_q.push_back(make_scan(KIND_MEASURE));
            endcase
        end
    endtask

    initial begin
        scan_t s;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            mdl_min[i] = 16'hFFFF; mdl_max[i] = 16'h0;
        end
        mdl_white = 0; mdl_noise = 64; mdl_line = 96; mdl_side = 1500;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: measure on cleared span, kind 3, extremes, timeout
        scan_q.push_back(fill_scan(KIND_MEASURE, 16'h0000));
        scan_q.push_back(fill_scan(2'd3, 16'h1234));
        scan_q.push_back(fill_scan(KIND_CAL, 16'd100));
        scan_q.push_back(fill_scan(KIND_MEASURE, 16'd100));
        scan_q.push_back(fill_scan(KIND_CAL, 16'd2100));
        scan_q.push_back(fill_scan(KIND_MEASURE, 16'hFFFF));
        scan_q.push_back(fill_scan(KIND_MEASURE, 16'd1100));
        scan_q.push_back(fill_scan(KIND_MEASURE, 16'h0000));
        s = fill_scan(KIND_MEASURE, 16'd100);
        s.raw[15:0] = 16'd2100; s.raw[31:16] = 16'd2100; s.raw[47:32] = 16'd2000;
        scan_q.push_back(s);
        s = fill_scan(KIND_MEASURE, 16'd100);
        s.raw[95:80] = 16'd2100; s.raw[79:64] = 16'd2100; s.raw[63:48] = 16'd2000;
        scan_q.push_back(s);
        s = fill_scan(KIND_MEASURE, 16'd100);
        s.raw[15:0] = 16'd2100; s.raw[95:80] = 16'd2100;
        scan_q.push_back(s);
        s = fill_scan(KIND_MEASURE, 16'd100);
        s.raw[47:32] = 16'd1800; s.raw[63:48] = 16'd1900;
        scan_q.push_back(s);
        scan_q.push_back(fill_scan(KIND_CAL, 16'hFFFE));
        scan_q.push_back(fill_scan(KIND_CAL, 16'h0000));
        scan_q.push_back(fill_scan(KIND_MEASURE, 16'h7FFF));
        scan_q.push_back(fill_scan(KIND_MEASURE, 16'hFFFE));
        scan_q.push_back(fill_scan(KIND_CLEAR, 16'hFFFF));
        scan_q.push_back(fill_scan(KIND_MEASURE, 16'hFFFF));
        drain();

        // register extremes and random settings between sessions
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_WHITE, 13'd1); write_reg(REG_NOISE, 13'd0);
                    write_reg(REG_LINE, 13'd0); write_reg(REG_SIDE, 13'd0);
                end
                1: begin
                    write_reg(REG_WHITE, 13'd0); write_reg(REG_NOISE, 13'd1000);
                    write_reg(REG_LINE, 13'd1000); write_reg(REG_SIDE, 13'd6000);
                end
                2: begin
                    write_reg(REG_NOISE, 13'h1FFF); write_reg(REG_LINE, 13'h03FF);
                    write_reg(REG_SIDE, 13'h1FFF); write_reg(REG_WHITE, 13'h1FFE);
                end
                3: begin
                    write_reg(REG_WHITE, 13'd0); write_reg(REG_NOISE, 13'd64);
                    write_reg(REG_LINE, 13'd96); write_reg(REG_SIDE, 13'd1500);
                end
                default: begin
                    write_reg(REG_WHITE, 13'($urandom_range(0, 1)));
                    write_reg(REG_NOISE, 13'($urandom_range(0, 300)));
                    write_reg(REG_LINE, 13'($urandom_range(0, 600)));
                    write_reg(REG_SIDE, 13'($urandom_range(0, 3000)));
                end
            endcase
            for (int k = 0; k < 4; k++) queue_session(13);
            if (ph == 4) begin
                // hold the sender until all results are back
                while (meas_q.size() > 0 || scan_q.size() > 30) @(posedge aclk);
                hold_tx = 1'b1;
                while (meas_q.size() > 0 || s_axis_tvalid) @(posedge aclk);
                hold_tx = 1'b0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
